FILE: rtl/srs_pkg.sv
// Shared types and constants for the streaming find-and-replace block.
// Used by srs_win_cell, srs_out_cell and substring_replace_stream_top.
`timescale 1ns / 1ps

package srs_pkg;

  // Default bounds on pattern and replacement length (bytes)
  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PAT_BYTES = 2'd0,
    REG_PAT_LEN   = 2'd1,
    REG_REP_BYTES = 2'd2,
    REG_REP_LEN   = 2'd3
  } srs_reg_e;

  // One result item
  typedef struct packed {
    logic       last;
    logic       vld;
    logic [7:0] data;
  } srs_item_t;

  // Control for one window cell
  typedef struct packed {
    logic sel;    // incoming byte lands in this cell
    logic shift;  // take the neighbor's byte (oldest byte leaves)
    logic en;     // an item is accepted this cycle
  } srs_win_ctl_t;

  // Control for one output buffer cell
  typedef struct packed {
    logic load;   // take an item of the new burst
    logic shift;  // take the neighbor's item (head item taken)
  } srs_out_ctl_t;

endpackage

FILE: rtl/srs_win_cell.sv
// One byte of the match window: holds a text byte, compares it to its pattern byte.
// Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_win_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srs_pkg::srs_win_ctl_t ctl_i,
  input  logic [7:0]           in_byte_i,   // incoming text byte
  input  logic [7:0]           pat_byte_i,  // pattern byte for this position
  input  logic [7:0]           nb_byte_i,   // content of the next younger cell
  output logic [7:0]           cur_byte_o,  // content including this item's byte
  output logic                 eq_o
);

  logic [7:0] byte_q, byte_d;

  // Content as seen by this item
  assign cur_byte_o = ctl_i.sel ? in_byte_i : byte_q;
  assign eq_o       = (cur_byte_o == pat_byte_i);

  // Hold, write or shift down
  always_comb begin
    byte_d = byte_q;
    if (ctl_i.en) begin
      byte_d = ctl_i.shift ? nb_byte_i : cur_byte_o;
    end
  end

  // Clear on reset; the fill count decides which bytes are live
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

FILE: rtl/srs_out_cell.sv
// One slot of the output burst buffer; slot 0 drives the result channel.
// Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_out_cell (
  input  logic                  clk_i,
  input  srs_pkg::srs_out_ctl_t ctl_i,
  input  srs_pkg::srs_item_t    load_item_i,
  input  srs_pkg::srs_item_t    nb_item_i,
  output srs_pkg::srs_item_t    item_o
);

  srs_pkg::srs_item_t item_q, item_d;

  // Load a new item, advance toward the head, or hold
  always_comb begin
    item_d = item_q;
    if (ctl_i.load) begin
      item_d = load_item_i;
    end else if (ctl_i.shift) begin
      item_d = nb_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;

endmodule

FILE: rtl/substring_replace_stream_top.sv
// Streaming find-and-replace of non-overlapping pattern occurrences.
// Uses srs_pkg, srs_win_cell (match window) and srs_out_cell (burst buffer).
//
// Usage:
//   Input channel s_axis_*: one text byte per item; tuser flags a valid byte,
//   tlast ends the string and flushes the held bytes.
//   Output channel m_axis_*: one text byte per item; tuser flags a valid
//   byte (clear only on a bare end marker), tlast marks the final item.
//   Configuration: write pattern, lengths and replacement through cfg_*
//   while the block is idle. Writing the pattern length empties the window.
// Each result of an accepted item is registered in the output buffer and offered from slot 0.
// Throughput: one item per cycle while each item yields at most one result
//   and m_axis_tready is high. An item yielding n results (replacement burst
//   or end flush, n up to max(MAX_PATTERN, MAX_REPLACEMENT)) keeps s_axis_tready
//   low until at most one result is buffered; the buffer drains one item per cycle while m_axis_tready is high.
// s_axis_tready is high while at most one result is buffered, so it does
//   not depend on m_axis_tready in the same cycle.
// Reset: window empty, buffer empty (slot contents are not reset); no clearing pass.
// Stall: when the receiver holds m_axis_tready low the buffer fills and
//   input is held off; no result is dropped.
`timescale 1ns / 1ps

module substring_replace_stream_top #(
  parameter int MAX_PATTERN     = srs_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = srs_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input text stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] text_byte
  input  logic        s_axis_tuser_i,  // [0] has_byte
  input  logic        s_axis_tlast_i,  // end_of_text
  // output text stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic        m_axis_tuser_o,  // [0] byte_valid
  output logic        m_axis_tlast_o   // last_of_text
);

  localparam int PLW   = $clog2(MAX_PATTERN + 1);
  localparam int RLW   = $clog2(MAX_REPLACEMENT + 1);
  localparam int BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int BW    = $clog2(BURST + 1);
  localparam int OB    = BURST + 1;
  localparam int CW    = $clog2(OB + 1);

  // Configuration registers
  logic [MAX_PATTERN*8-1:0]     pat_q;
  logic [MAX_REPLACEMENT*8-1:0] rep_q;
  logic [3:0]                   plen_raw_q, rlen_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q      <= '0;
      rep_q      <= '0;
      plen_raw_q <= '0;
      rlen_raw_q <= '0;
    end else if (cfg_we_i) begin
      unique case (srs_pkg::srs_reg_e'(cfg_idx_i))
        srs_pkg::REG_PAT_BYTES: pat_q      <= cfg_wdata_i[MAX_PATTERN*8-1:0];
        srs_pkg::REG_PAT_LEN:   plen_raw_q <= cfg_wdata_i[3:0];
        srs_pkg::REG_REP_BYTES: rep_q      <= cfg_wdata_i[MAX_REPLACEMENT*8-1:0];
        srs_pkg::REG_REP_LEN:   rlen_raw_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp lengths to the configured bounds
  logic [PLW-1:0] plen;
  logic [RLW-1:0] rlen;
  assign plen = (plen_raw_q > 4'(MAX_PATTERN)) ? PLW'(MAX_PATTERN) : PLW'(plen_raw_q);
  assign rlen = (rlen_raw_q > 4'(MAX_REPLACEMENT)) ? RLW'(MAX_REPLACEMENT)
                                                   : RLW'(rlen_raw_q);

  // Handshakes
  logic [CW-1:0] cnt_q, cnt_d;
  logic          acc, pop, has, eot;

  assign s_axis_tready_o = (cnt_q <= CW'(1));
  assign acc = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign pop = m_axis_tvalid_o & m_axis_tready_i;
  assign has = s_axis_tuser_i;
  assign eot = s_axis_tlast_i;

  // Window fill and cell row
  logic [PLW-1:0]   fill_q, fill_d, fill_n;
  logic [7:0]       wcur [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq, in_use;
  logic             full, match, rep, mis;

  assign fill_n = fill_q + PLW'(has && (plen != '0));
  assign full   = has && (plen != '0) && (fill_n == plen);
  assign match  = &(eq | ~in_use);
  assign rep    = full && match;
  assign mis    = full && !match;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
    srs_pkg::srs_win_ctl_t wctl;
    logic [7:0]            nb;

    assign in_use[i]  = (PLW'(i) < plen);
    assign wctl.sel   = has && (fill_q == PLW'(i));
    assign wctl.shift = mis;
    assign wctl.en    = acc;

    if (i < MAX_PATTERN - 1) begin : g_nb
      assign nb = wcur[i+1];
    end else begin : g_end
      assign nb = 8'h00;
    end

    srs_win_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (wctl),
      .in_byte_i  (s_axis_tdata_i),
      .pat_byte_i (pat_q[8*i +: 8]),
      .nb_byte_i  (nb),
      .cur_byte_o (wcur[i]),
      .eq_o       (eq[i])
    );
  end

  // Next window fill
  always_comb begin
    fill_d = fill_q;
    if (cfg_we_i && (srs_pkg::srs_reg_e'(cfg_idx_i) == srs_pkg::REG_PAT_LEN)) begin
      fill_d = '0;
    end else if (acc) begin
      if (eot || rep || (plen == '0)) begin
        fill_d = '0;
      end else if (mis) begin
        fill_d = plen - PLW'(1);
      end else begin
        fill_d = fill_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Burst of results caused by this item
  logic [PLW-1:0] emit;
  logic [BW-1:0]  n_raw, n;
  logic           marker;
  srs_pkg::srs_item_t burst [BURST];

  always_comb begin
    if (plen == '0) begin
      emit = PLW'(has);
    end else if (eot) begin
      emit = fill_n;
    end else begin
      emit = PLW'(mis);
    end
  end

  assign n_raw  = rep ? BW'(rlen) : BW'(emit);
  assign marker = eot && (n_raw == '0);
  assign n      = marker ? BW'(1) : n_raw;

  for (genvar j = 0; j < BURST; j++) begin : g_burst
    logic [7:0] rbyte, wbyte;

    if (j < MAX_REPLACEMENT) begin : g_r
      assign rbyte = rep_q[8*j +: 8];
    end else begin : g_rz
      assign rbyte = 8'h00;
    end
    if (j < MAX_PATTERN) begin : g_w
      assign wbyte = wcur[j];
    end else begin : g_wz
      assign wbyte = 8'h00;
    end

    assign burst[j].data = marker ? 8'h00 : (rep ? rbyte : wbyte);
    assign burst[j].vld  = !marker;
    assign burst[j].last = eot && (BW'(j) == n - BW'(1));
  end

  // Output burst buffer: load behind the item still waiting, drain from slot 0
  logic               base1;
  srs_pkg::srs_item_t ob [OB];

  assign base1 = (cnt_q == CW'(1)) && !pop;

  for (genvar k = 0; k < OB; k++) begin : g_out
    srs_pkg::srs_out_ctl_t octl;
    srs_pkg::srs_item_t    ld_item, nb_item;
    logic                  ld0, ld1;

    if (k < BURST) begin : g_l0
      assign ld0 = (n > BW'(k));
    end else begin : g_l0z
      assign ld0 = 1'b0;
    end
    if (k >= 1) begin : g_l1
      assign ld1 = (n > BW'(k - 1));
    end else begin : g_l1z
      assign ld1 = 1'b0;
    end

    if (k >= 1 && k < BURST) begin : g_sel
      assign ld_item = base1 ? burst[k-1] : burst[k];
    end else if (k >= 1) begin : g_selb
      assign ld_item = burst[k-1];
    end else begin : g_sela
      assign ld_item = burst[k];
    end

    if (k < OB - 1) begin : g_nb
      assign nb_item = ob[k+1];
    end else begin : g_nbz
      assign nb_item = '0;
    end

    assign octl.load  = acc && (base1 ? ld1 : ld0);
    assign octl.shift = pop;

    srs_out_cell u_slot (
      .clk_i       (clk_i),
      .ctl_i       (octl),
      .load_item_i (ld_item),
      .nb_item_i   (nb_item),
      .item_o      (ob[k])
    );
  end

  // Buffer occupancy
  assign cnt_d = cnt_q - CW'(pop) + (acc ? CW'(n) : CW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tdata_o = ob[0].data;
  assign m_axis_tuser_o = ob[0].vld;
  assign m_axis_tlast_o = ob[0].last;

  // Buffer never holds more than its slots
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(OB))
    else $error("output buffer overflow");

  // Window never holds a full pattern between items
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) || (fill_q < plen))
    else $error("window fill out of range");

  // End of text empties the window
  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tlast_i |=> fill_q == '0)
    else $error("window not empty after end of text");

  // A bare end marker is always the final item
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("end marker without last flag");

endmodule
